// File: hdl/oss_pkg.sv
`timescale 1ns / 1ps
// oss_pkg: shared types and defaults for the order statistic set
// no dependencies

package oss_pkg;

    localparam int CAPACITY_DEFAULT  = 1024;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam int KEY_BITS   = 32;
    localparam int RANK_BITS  = 10;
    localparam int COUNT_BITS = 11;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_ERASE  = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [KEY_BITS-1:0]  key;
        logic [RANK_BITS-1:0] rank;
    } oss_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   kth_key;
        logic                  rank_invalid;
        logic                  insert_dropped;
        logic [COUNT_BITS-1:0] key_count;
    } oss_result_t;

endpackage

// File: hdl/oss_stream_if.sv
`timescale 1ns / 1ps
// oss_stream_if: valid/ready channel carrying one word of type payload_t
// payload types come from oss_pkg

interface oss_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/oss_key_store.sv
`timescale 1ns / 1ps
// oss_key_store: single write, single read key memory with registered read data
// no dependencies

module oss_key_store #(
    parameter int DEPTH      = 1024,
    parameter int WIDTH      = 32,
    parameter int ADDR_WIDTH = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_WIDTH-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/order_statistic_set_core.sv
`timescale 1ns / 1ps
// order_statistic_set_core: sorted key set with insert, erase and rank lookup
// depends on oss_pkg, oss_stream_if, oss_key_store
//
// usage
//   item channel (sink): action, key, rank; one word is taken only while the
//   block is idle, and each word gives exactly one word on the result channel
//   result channel (source): kth_key, rank_invalid, insert_dropped, key_count
//   keys live ascending in one single-port-read memory; a binary search finds
//   the key's position, each probe a read state and then a compare state, then
//   an insert or erase moves the tail one entry at a time (read, then write)
//   after the search come a presence check, the tail move when the set changes,
//   a rank read and the done step; a duplicate, absent erase or dropped insert
//   moves nothing; no new word is taken until the last one leaves the done step
//   the result sits in an output register; a new word is taken while it
//   waits, and the next result waits in the done step until the held one is taken
//   reset empties the set at once; the memory needs no clearing pass

module order_statistic_set_core #(
    parameter int CAPACITY  = oss_pkg::CAPACITY_DEFAULT,
    parameter int KEY_WIDTH = oss_pkg::KEY_WIDTH_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    oss_stream_if.sink   item,
    oss_stream_if.source result
);

    import oss_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > RANK_BITS) ? CW : RANK_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_RANK = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE       = CW'(1);

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        mid_reg, mid_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 act_reg, act_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [RANK_BITS-1:0] rank_reg, rank_next;
    logic                 dropped_reg, dropped_next;
    logic                 out_valid_reg, out_valid_next;
    oss_result_t          out_reg, out_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [KEY_WIDTH-1:0] mem_rdata;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid_calc;
    logic [CW-1:0]        ptr_dec;
    logic [CW-1:0]        ptr_inc;
    logic                 present;
    logic                 rank_bad;

    oss_key_store #(
        .DEPTH      (CAPACITY),
        .WIDTH      (KEY_WIDTH),
        .ADDR_WIDTH (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CW:1];
    assign ptr_dec  = ptr_reg - ONE;
    assign ptr_inc  = ptr_reg + ONE;
    assign present  = (lo_reg < count_reg) && (mem_rdata == key_reg);
    assign rank_bad = CMPW'(rank_reg) >= CMPW'(count_reg);

    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        rank_next      = rank_reg;
        dropped_next   = dropped_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = mid_calc[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    act_next     = item.data.action;
                    key_next     = KEY_WIDTH'(item.data.key);
                    rank_next    = item.data.rank;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    dropped_next = 1'b0;
                    state_next   = S_SRCH;
                end
            end
            S_SRCH:
            begin
                mem_re = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    mem_raddr  = mid_calc[AW-1:0];
                    mid_next   = mid_calc;
                    state_next = S_SCMP;
                end
                else
                begin
                    mem_raddr  = lo_reg[AW-1:0];
                    state_next = S_PCHK;
                end
            end
            S_SCMP:
            begin
                if (mem_rdata < key_reg)
                begin
                    lo_next = mid_reg + ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_PCHK:
            begin
                state_next = S_RANK;
                if (act_reg == ACT_INSERT)
                begin
                    if (!present)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ptr_next   = count_reg;
                            state_next = S_SHRD;
                        end
                    end
                end
                else if (present)
                begin
                    ptr_next   = lo_reg;
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (ptr_reg > lo_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_dec[AW-1:0];
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = lo_reg[AW-1:0];
                        mem_wdata  = key_reg;
                        count_next = count_reg + ONE;
                        state_next = S_RANK;
                    end
                end
                else
                begin
                    if (ptr_inc < count_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_inc[AW-1:0];
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        count_next = count_reg - ONE;
                        state_next = S_RANK;
                    end
                end
            end
            S_SHWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                ptr_next   = (act_reg == ACT_INSERT) ? ptr_dec : ptr_inc;
                state_next = S_SHRD;
            end
            S_RANK:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(rank_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.kth_key        = rank_bad ? '0 : KEY_BITS'(mem_rdata);
                    out_next.rank_invalid   = rank_bad;
                    out_next.insert_dropped = dropped_reg;
                    out_next.key_count      = COUNT_BITS'(count_reg);
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        act_reg     <= act_next;
        key_reg     <= key_next;
        rank_reg    <= rank_next;
        dropped_reg <= dropped_next;
        out_reg     <= out_next;
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for order_statistic_set_core
// depends on oss_pkg, oss_stream_if and order_statistic_set_core

module tb_top;
    import oss_pkg::*;

    localparam int SET_CAPACITY  = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int REPORT_LIMIT  = 10;
    localparam int MIXED_WORDS   = 220;
    localparam int FULL_WORDS    = 48;

    typedef struct packed {
        logic        typed;
        oss_item_t   word;
        oss_result_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 18;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{1'b1, '{ACT_ERASE,  32'h0000_0005, 10'd0},    '{32'h0000_0000, 1'b1, 1'b0, 11'd0}},
        '{1'b1, '{ACT_INSERT, 32'hFFFF_FFFF, 10'd0},    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd1}},
        '{1'b1, '{ACT_INSERT, 32'h0000_0000, 10'd0},    '{32'h0000_0000, 1'b0, 1'b0, 11'd2}},
        '{1'b1, '{ACT_INSERT, 32'h0000_0000, 10'd1},    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd2}},
        '{1'b1, '{ACT_INSERT, 32'h8000_0000, 10'd1},    '{32'h8000_0000, 1'b0, 1'b0, 11'd3}},
        '{1'b1, '{ACT_INSERT, 32'h8000_0000, 10'd1023}, '{32'h0000_0000, 1'b1, 1'b0, 11'd3}},
        '{1'b1, '{ACT_ERASE,  32'h0000_1234, 10'd2},    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd3}},
        '{1'b1, '{ACT_ERASE,  32'hFFFF_FFFF, 10'd2},    '{32'h0000_0000, 1'b1, 1'b0, 11'd2}},
        '{1'b0, '{ACT_INSERT, 32'hAAAA_5555, 10'd2},    '0},
        '{1'b0, '{ACT_INSERT, 32'h5555_AAAA, 10'd1},    '0},
        '{1'b0, '{ACT_INSERT, 32'h7FFF_FFFF, 10'h2AA},  '0},
        '{1'b0, '{ACT_INSERT, 32'h0000_0001, 10'h155},  '0},
        '{1'b0, '{ACT_ERASE,  32'h0000_0000, 10'd0},    '0},
        '{1'b0, '{ACT_ERASE,  32'h8000_0000, 10'd1},    '0},
        '{1'b0, '{ACT_ERASE,  32'h7FFF_FFFF, 10'd0},    '0},
        '{1'b0, '{ACT_ERASE,  32'hAAAA_5555, 10'd0},    '0},
        '{1'b0, '{ACT_ERASE,  32'h5555_AAAA, 10'd0},    '0},
        '{1'b1, '{ACT_ERASE,  32'h0000_0001, 10'd0},    '{32'h0000_0000, 1'b1, 1'b0, 11'd0}}
    };

    logic clk;
    logic rst_n;

    oss_stream_if #(.payload_t(oss_item_t))   item_ch ();
    oss_stream_if #(.payload_t(oss_result_t)) result_ch ();

    order_statistic_set_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic [KEY_BITS-1:0] held_keys[$];
    oss_result_t         pending_results[$];
    int                  fail_count;
    int                  reported;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    longint              cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("order_statistic_set_core regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // first held position whose key is not below k
    function automatic int unsigned key_position(logic [KEY_BITS-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = held_keys.size();
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic oss_result_t apply_set_update(oss_item_t w);
        oss_result_t r;
        int unsigned pos;
        bit          present;
        r = '0;
        pos = key_position(w.key);
        present = (pos < held_keys.size()) && (held_keys[pos] == w.key);
        if (w.action == ACT_INSERT)
        begin
            if (!present)
            begin
                if (held_keys.size() >= SET_CAPACITY)
                    r.insert_dropped = 1'b1;
                else
                    held_keys.insert(pos, w.key);
            end
        end
        else if (present)
        begin
            held_keys.delete(pos);
        end
        r.key_count = COUNT_BITS'(held_keys.size());
        if (w.rank >= held_keys.size())
            r.rank_invalid = 1'b1;
        else
            r.kth_key = held_keys[w.rank];
        return r;
    endfunction

    task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
        fail_count++;
        if (reported < REPORT_LIMIT)
            $display("mismatch %s: expected %0h, got %0h at cycle %0d",
                     field, want, got, cycle_count);
        reported++;
    endtask

    task automatic check_result(oss_result_t got);
        oss_result_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (reported < REPORT_LIMIT)
                $display("unexpected result word %0h at cycle %0d", got, cycle_count);
            reported++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kth_key !== want.kth_key)
                note_mismatch("kth_key", want.kth_key, got.kth_key);
            if (got.rank_invalid !== want.rank_invalid)
                note_mismatch("rank_invalid", want.rank_invalid, got.rank_invalid);
            if (got.insert_dropped !== want.insert_dropped)
                note_mismatch("insert_dropped", want.insert_dropped, got.insert_dropped);
            if (got.key_count !== want.key_count)
                note_mismatch("key_count", want.key_count, got.key_count);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result(result_ch.data);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(oss_item_t w, bit typed, oss_result_t want);
        int          gap;
        oss_result_t predicted;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predicted = apply_set_update(w);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // hold off until every result is back, then switch idling
    task automatic settle_set(int next_tx, int next_rx, int hold);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        tx_idle_pct = next_tx;
        rx_idle_pct = next_rx;
        repeat (hold) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] corner_key();
        if ($urandom_range(1))
            return KEY_BITS'($urandom_range(3));
        return ~KEY_BITS'($urandom_range(3));
    endfunction

    // small set, random insert/erase mix around a few dozen keys
    task automatic run_mixed_phase(int words);
        oss_item_t w;
        int        erase_pct;
        int        pick;
        for (int n = 0; n < words; n++)
        begin
            erase_pct = (held_keys.size() < 16) ? 25 : (held_keys.size() > 48) ? 75 : 45;
            w.action = ($urandom_range(99) < erase_pct) ? ACT_ERASE : ACT_INSERT;
            pick = $urandom_range(99);
            if (held_keys.size() != 0 && pick < ((w.action == ACT_ERASE) ? 75 : 15))
                w.key = held_keys[$urandom_range(held_keys.size() - 1)];
            else if (pick < 90)
                w.key = $urandom;
            else
                w.key = corner_key();
            if ($urandom_range(99) < 80)
                w.rank = RANK_BITS'($urandom_range(held_keys.size()));
            else
                w.rank = RANK_BITS'($urandom_range(1023));
            send_word(w, 1'b0, '0);
        end
    endtask

    // empty the set top down, fill it in ascending order, then work at capacity
    task automatic fill_and_hold();
        oss_item_t           w;
        logic [KEY_BITS-1:0] next_key;
        while (held_keys.size() != 0)
        begin
            w.action = ACT_ERASE;
            w.key    = held_keys[held_keys.size() - 1];
            w.rank   = RANK_BITS'($urandom_range(held_keys.size()));
            send_word(w, 1'b0, '0);
        end
        next_key = KEY_BITS'($urandom_range(1 << 20));
        while (held_keys.size() < SET_CAPACITY)
        begin
            w.action = ACT_INSERT;
            w.rank   = RANK_BITS'($urandom_range(1023));
            if (held_keys.size() != 0 && $urandom_range(99) < 5)
            begin
                w.key = held_keys[$urandom_range(held_keys.size() - 1)];
            end
            else
            begin
                w.key = next_key;
                next_key += KEY_BITS'($urandom_range(4_000_000, 1));
            end
            send_word(w, 1'b0, '0);
        end
        for (int n = 0; n < FULL_WORDS; n++)
        begin
            w.rank = RANK_BITS'($urandom_range(1023));
            case ($urandom_range(3))
                0:
                begin
                    w.action = ACT_INSERT;
                    w.key    = $urandom;
                end
                1:
                begin
                    w.action = ACT_INSERT;
                    w.key    = held_keys[$urandom_range(held_keys.size() - 1)];
                end
                2:
                begin
                    w.action = ACT_ERASE;
                    w.key    = held_keys[$urandom_range(held_keys.size() - 1)];
                end
                default:
                begin
                    w.action = ACT_ERASE;
                    w.key    = $urandom;
                end
            endcase
            send_word(w, 1'b0, '0);
        end
    endtask

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        rst_n           = 1'b0;
        fail_count      = 0;
        reported        = 0;
        cycle_count     = 0;
        tx_idle_pct     = 34;
        rx_idle_pct     = 73;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
        run_mixed_phase(MIXED_WORDS);
        settle_set(73, 34, $urandom_range(20));
        run_mixed_phase(MIXED_WORDS);
        settle_set(0, 0, $urandom_range(20));
        fill_and_hold();
        settle_set(0, 0, SETTLE_CYCLES);

        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("order_statistic_set_core regression: pass");
        else
            $display("order_statistic_set_core regression: fail");
        $finish;
    end

endmodule
